// ===== hdl/bafmt_pkg.sv =====
// Package for the binary to ASCII number formatter.
// Holds the sizing constants, ASCII codes, cell and state codes, and the digit function.
// No dependencies.
package bafmt_pkg;

  localparam int unsigned VALUE_BITS         = 64;
  localparam int unsigned MAX_DECIMAL_DIGITS = 20;
  localparam int unsigned HEX_DIGITS         = (VALUE_BITS + 3) / 4;
  localparam int unsigned NUM_CELLS          = (MAX_DECIMAL_DIGITS > HEX_DIGITS) ?
                                               MAX_DECIMAL_DIGITS : HEX_DIGITS;
  localparam int unsigned BIT_CNT_W          = $clog2(VALUE_BITS);
  localparam int unsigned DIG_CNT_W          = $clog2(NUM_CELLS + 1);

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  localparam logic OPCODE_DEC = 1'b0;
  localparam logic OPCODE_HEX = 1'b1;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_CONV_DEC,
    CELL_CONV_HEX,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_PREFIX_ZERO,
    ST_PREFIX_X,
    ST_SKIP,
    ST_EMIT
  } state_e;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'b0000, d};
    end
    return base + {4'b0000, d} - 8'd10;
  endfunction

endpackage

// ===== hdl/bafmt_ifs.sv =====
// Channel interfaces of the number formatter: input items, result items, configuration.
// Depends on bafmt_pkg for the value width.
interface bafmt_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [bafmt_pkg::VALUE_BITS-1:0]    value;
  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface bafmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

interface bafmt_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bafmt_cell.sv =====
// One digit cell of the conversion chain: a 4-bit digit with shift-and-add-3 step
// (decimal) or plain shift (hex); depends on bafmt_pkg for the cell operation codes.
module bafmt_cell (
  input  logic                clk_i,
  input  bafmt_pkg::cell_op_e op_i,
  input  logic                carry_i,
  input  logic [3:0]          digit_i,
  output logic                carry_o,
  output logic [3:0]          digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  always_comb begin
    adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    carry_o = (op_i == bafmt_pkg::CELL_CONV_HEX) ? digit_q[3] : adj[3];
    case (op_i)
      bafmt_pkg::CELL_CLEAR:    digit_d = 4'd0;
      bafmt_pkg::CELL_CONV_DEC: digit_d = {adj[2:0], carry_i};
      bafmt_pkg::CELL_CONV_HEX: digit_d = {digit_q[2:0], carry_i};
      bafmt_pkg::CELL_SHIFT:    digit_d = digit_i;
      default:                  digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

// ===== hdl/bafmt_chain.sv =====
// Row of digit cells: converts a bit stream to decimal or hex digits, then shifts
// the digits toward the top cell for output. Depends on bafmt_pkg and bafmt_cell.
module bafmt_chain (
  input  logic                clk_i,
  input  bafmt_pkg::cell_op_e op_i,
  input  logic                bit_i,
  output logic [3:0]          top_digit_o,
  output logic                ovf_o
);

  logic       carry [bafmt_pkg::NUM_CELLS];
  logic [3:0] digit [bafmt_pkg::NUM_CELLS];

  for (genvar i = 0; i < bafmt_pkg::NUM_CELLS; i++) begin : g_cell
    logic       c_in;
    logic [3:0] d_in;
    if (i == 0) begin : g_first
      assign c_in = bit_i;
      assign d_in = 4'd0;
    end else if (i == bafmt_pkg::MAX_DECIMAL_DIGITS) begin : g_dec_edge
      assign c_in = (op_i == bafmt_pkg::CELL_CONV_DEC) ? 1'b0 : carry[i-1];
      assign d_in = digit[i-1];
    end else begin : g_mid
      assign c_in = carry[i-1];
      assign d_in = digit[i-1];
    end
    bafmt_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op_i),
      .carry_i (c_in),
      .digit_i (d_in),
      .carry_o (carry[i]),
      .digit_o (digit[i])
    );
  end

  assign top_digit_o = digit[bafmt_pkg::NUM_CELLS-1];
  assign ovf_o       = carry[bafmt_pkg::MAX_DECIMAL_DIGITS-1];

endmodule

// ===== hdl/binary_to_ascii_number_formatter_unit.sv =====
// After the bit-serial conversion, hex mode first registers the prefix characters '0' and 'x'.
// Both modes then shift leading zero cells out of the chain, keeping at least one digit.
// A new item is taken only in ST_IDLE, once the last character of the previous item is loaded;
// sink stalls hold the prefix and digit output states.
// Reset is asynchronous and active low; it empties the output and sets upper_q (upper-case hex).
// Depends on bafmt_pkg, bafmt_ifs and bafmt_chain.
module binary_to_ascii_number_formatter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  bafmt_in_if.sink    in_i,
  bafmt_out_if.source out_o,
  bafmt_cfg_if.sink   cfg_i
);

  bafmt_pkg::state_e   state_q, state_d;
  bafmt_pkg::cell_op_e cell_op;

  logic [bafmt_pkg::VALUE_BITS-1:0] value_q, value_d;
  logic                             mode_q, mode_d;
  logic                             ovf_q, ovf_d;
  logic [bafmt_pkg::BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [bafmt_pkg::DIG_CNT_W-1:0]  dig_cnt_q, dig_cnt_d;
  logic                             out_valid_q, out_valid_d;
  logic [7:0]                       char_q, char_d;
  logic                             last_q, last_d;
  logic                             upper_q;
  logic [3:0]                       top_digit;
  logic                             chain_ovf;
  logic                             out_free;
  logic                             load;
  logic                             keep_all;

  bafmt_chain u_chain (
    .clk_i       (clk_i),
    .op_i        (cell_op),
    .bit_i       (value_q[bafmt_pkg::VALUE_BITS-1]),
    .top_digit_o (top_digit),
    .ovf_o       (chain_ovf)
  );

  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;
  assign keep_all    = ovf_q &&
                       (dig_cnt_q <= bafmt_pkg::DIG_CNT_W'(bafmt_pkg::MAX_DECIMAL_DIGITS));

  always_comb begin
    state_d    = state_q;
    value_d    = value_q;
    mode_d     = mode_q;
    ovf_d      = ovf_q;
    bit_cnt_d  = bit_cnt_q;
    dig_cnt_d  = dig_cnt_q;
    char_d     = char_q;
    last_d     = last_q;
    load       = 1'b0;
    cell_op    = bafmt_pkg::CELL_HOLD;
    in_i.ready = 1'b0;
    case (state_q)
      bafmt_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          value_d   = in_i.value;
          mode_d    = in_i.opcode;
          ovf_d     = 1'b0;
          bit_cnt_d = '0;
          cell_op   = bafmt_pkg::CELL_CLEAR;
          state_d   = bafmt_pkg::ST_CONVERT;
        end
      end
      bafmt_pkg::ST_CONVERT: begin
        cell_op   = (mode_q == bafmt_pkg::OPCODE_HEX) ? bafmt_pkg::CELL_CONV_HEX :
                                                        bafmt_pkg::CELL_CONV_DEC;
        value_d   = {value_q[bafmt_pkg::VALUE_BITS-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (mode_q == bafmt_pkg::OPCODE_DEC && chain_ovf) begin
          ovf_d = 1'b1;
        end
        if (bit_cnt_q == bafmt_pkg::BIT_CNT_W'(bafmt_pkg::VALUE_BITS - 1)) begin
          dig_cnt_d = bafmt_pkg::DIG_CNT_W'(bafmt_pkg::NUM_CELLS);
          state_d   = (mode_q == bafmt_pkg::OPCODE_HEX) ? bafmt_pkg::ST_PREFIX_ZERO :
                                                          bafmt_pkg::ST_SKIP;
        end
      end
      bafmt_pkg::ST_PREFIX_ZERO: begin
        if (out_free) begin
          load    = 1'b1;
          char_d  = bafmt_pkg::CHAR_ZERO;
          last_d  = 1'b0;
          state_d = bafmt_pkg::ST_PREFIX_X;
        end
      end
      bafmt_pkg::ST_PREFIX_X: begin
        if (out_free) begin
          load    = 1'b1;
          char_d  = bafmt_pkg::CHAR_X;
          last_d  = 1'b0;
          state_d = bafmt_pkg::ST_SKIP;
        end
      end
      bafmt_pkg::ST_SKIP: begin
        if (top_digit == 4'd0 && dig_cnt_q > bafmt_pkg::DIG_CNT_W'(1) && !keep_all) begin
          cell_op   = bafmt_pkg::CELL_SHIFT;
          dig_cnt_d = dig_cnt_q - 1'b1;
        end else begin
          state_d = bafmt_pkg::ST_EMIT;
        end
      end
      bafmt_pkg::ST_EMIT: begin
        if (out_free) begin
          load      = 1'b1;
          char_d    = bafmt_pkg::digit_char(top_digit, upper_q);
          last_d    = (dig_cnt_q == bafmt_pkg::DIG_CNT_W'(1));
          cell_op   = bafmt_pkg::CELL_SHIFT;
          dig_cnt_d = dig_cnt_q - 1'b1;
          if (dig_cnt_q == bafmt_pkg::DIG_CNT_W'(1)) begin
            state_d = bafmt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = bafmt_pkg::ST_IDLE;
      end
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bafmt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      upper_q     <= 1'b1;
      ovf_q       <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ovf_q       <= ovf_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      if (cfg_i.valid) begin
        upper_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    mode_q  <= mode_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

endmodule

// ===== tb/binary_to_ascii_number_formatter_unit_tb.sv =====
// Testbench for binary_to_ascii_number_formatter_unit: a directed table, then random phases.
// Every character is checked against the table text or a predictor that tracks the hex letter case setting.
// Depends on bafmt_pkg, bafmt_ifs and the formatter RTL.
module binary_to_ascii_number_formatter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned MAX_REPORTS    = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } fmt_char_t;

  typedef struct {
    row_kind_e   kind;
    logic        opcode;
    logic [63:0] value;
    string       text;
  } fmt_row_t;

  fmt_row_t directed_rows[24] = '{
    '{ROW_ITEM, bafmt_pkg::OPCODE_DEC, 64'd0, "0"},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'd0, "0x0"},
    '{ROW_ITEM, bafmt_pkg::OPCODE_DEC, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'hFFFF_FFFF_FFFF_FFFF, "0xFFFFFFFFFFFFFFFF"},
    '{ROW_ITEM, bafmt_pkg::OPCODE_DEC, 64'd1, "1"},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'd1, "0x1"},
    '{ROW_ITEM, bafmt_pkg::OPCODE_DEC, 64'd9, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_DEC, 64'd10, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_DEC, 64'd9999999999999999999, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_DEC, 64'd10000000000000000000, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_DEC, 64'h8000_0000_0000_0000, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'h8000_0000_0000_0000, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'h0123_4567_89AB_CDEF, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'hFEDC_BA98_7654_3210, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'hA, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'h10, ""},
    '{ROW_CFG, bafmt_pkg::OPCODE_DEC, 64'd0, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'hFFFF_FFFF_FFFF_FFFF, "0xffffffffffffffff"},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'h0123_4567_89AB_CDEF, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'hFEDC_BA98_7654_3210, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'hF, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_DEC, 64'd12345678901234567890, ""},
    '{ROW_CFG, bafmt_pkg::OPCODE_DEC, 64'd1, ""},
    '{ROW_ITEM, bafmt_pkg::OPCODE_HEX, 64'hABCD_EF00, ""}
  };

  int unsigned phase_items[4]  = '{160, 90, 90, 110};
  int unsigned phase_send[4]   = '{0, 85, 0, 23};
  int unsigned phase_stall[4]  = '{0, 0, 85, 23};
  logic        phase_upper[4]  = '{1'b1, 1'b0, 1'b1, 1'b0};

  logic clk_i;
  logic rst_ni;

  bafmt_in_if  in_bus ();
  bafmt_out_if out_bus ();
  bafmt_cfg_if cfg_bus ();

  binary_to_ascii_number_formatter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  fmt_char_t   expected_chars_q[$];
  fmt_char_t   oldest_char;
  logic        upper_hex_setting;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] ascii_of_digit(input logic [3:0] d, input logic upper);
    if (d < 4'd10) begin
      return bafmt_pkg::CHAR_ZERO + 8'(d);
    end
    return (upper ? bafmt_pkg::CHAR_UPPER_A : bafmt_pkg::CHAR_LOWER_A) + 8'(d) - 8'd10;
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic is_last);
    fmt_char_t entry;
    entry.character = c;
    entry.last = is_last;
    expected_chars_q.push_back(entry);
  endfunction

  function automatic void queue_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      push_char(text[i], i == text.len() - 1);
    end
  endfunction

  function automatic void predict_format(input logic opcode, input logic [63:0] value,
                                         input logic upper);
    logic [bafmt_pkg::VALUE_BITS-1:0] v;
    logic [7:0]                       digits[$];
    v = value[bafmt_pkg::VALUE_BITS-1:0];
    if (opcode == bafmt_pkg::OPCODE_HEX) begin
      push_char(bafmt_pkg::CHAR_ZERO, 1'b0);
      push_char(bafmt_pkg::CHAR_X, 1'b0);
      while (v != 0 && digits.size() < bafmt_pkg::HEX_DIGITS) begin
        digits.push_back(ascii_of_digit(v[3:0], upper));
        v = v >> 4;
      end
    end else begin
      while (v != 0 && digits.size() < bafmt_pkg::MAX_DECIMAL_DIGITS) begin
        digits.push_back(ascii_of_digit(4'(v % 10), 1'b0));
        v = v / 10;
      end
    end
    if (digits.size() == 0) begin
      push_char(bafmt_pkg::CHAR_ZERO, 1'b1);
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      push_char(digits[i], i == 0);
    end
  endfunction

  function automatic logic [63:0] pick_test_value();
    logic [63:0] v;
    int unsigned bits;
    if ($urandom_range(7) == 0) begin
      v = 64'd1;
      repeat ($urandom_range(19, 1)) v = v * 64'd10;
      return v + 64'($urandom_range(2)) - 64'd1;
    end
    v = {$urandom, $urandom};
    bits = ($urandom_range(3) == 0) ? 64 : $urandom_range(63);
    if (bits < 64) begin
      v = v & ((64'd1 << bits) - 64'd1);
    end
    return v;
  endfunction

  task automatic send_item(input logic opcode, input logic [63:0] value, input string text);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid  <= 1'b1;
    in_bus.opcode <= opcode;
    in_bus.value  <= value;
    do @(posedge clk_i); while (!in_bus.ready);
    if (text.len() != 0) begin
      queue_text(text);
    end else begin
      predict_format(opcode, value, upper_hex_setting);
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_chars_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_case_setting(input logic upper);
    wait_all_results();
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= upper;
    do @(posedge clk_i); while (!cfg_bus.ready);
    upper_hex_setting = upper;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_chars_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $error("unexpected character 8'h%02h, last %b", out_bus.character, out_bus.last);
        end
        mismatch_count++;
      end else begin
        oldest_char = expected_chars_q.pop_front();
        if (out_bus.character !== oldest_char.character) begin
          if (mismatch_count < MAX_REPORTS) begin
            $error("character: expected 8'h%02h, got 8'h%02h",
                   oldest_char.character, out_bus.character);
          end
          mismatch_count++;
        end
        if (out_bus.last !== oldest_char.last) begin
          if (mismatch_count < MAX_REPORTS) begin
            $error("last: expected %b, got %b", oldest_char.last, out_bus.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.opcode     = bafmt_pkg::OPCODE_DEC;
    in_bus.value      = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.data      = 1'b0;
    upper_hex_setting = 1'b1;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_request      = 1'b0;
    mismatch_count    = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_case_setting(directed_rows[r].value[0]);
      end else begin
        send_item(directed_rows[r].opcode, directed_rows[r].value, directed_rows[r].text);
      end
    end

    for (int p = 0; p < 4; p++) begin
      write_case_setting(phase_upper[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 0 && i == 40) begin
          hold_request = 1'b1;
        end
        if (p == 3 && i == 45) begin
          wait_all_results();
        end
        send_item($urandom_range(1) ? bafmt_pkg::OPCODE_HEX : bafmt_pkg::OPCODE_DEC,
                  pick_test_value(), "");
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bafmt_pkg.sv
hdl/bafmt_ifs.sv
hdl/bafmt_cell.sv
hdl/bafmt_chain.sv
hdl/binary_to_ascii_number_formatter_unit.sv
tb/binary_to_ascii_number_formatter_unit_tb.sv
